// ===== hdl/double_hash_table_engine_defines.svh =====
// Assertion macros for the double hash table engine.
// Used by the top level; expects signals clk and rst_n in the calling scope.
`ifndef DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DHTE_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DHTE_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dhte_pkg.sv =====
// Shared types and constants of the double hash table engine.
// No dependencies; used by the top level and the hash unit.
package dhte_pkg;

    localparam int CAP_WIDTH   = 11;
    localparam int COUNT_WIDTH = 11;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 11'd1021;
    // Remainder bits retired per cycle in the hash unit.
    localparam int DIV_STEPS   = 4;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } dhte_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } dhte_status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } dhte_mark_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH
    } dhte_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dhte_unit_st_t;

endpackage

// ===== hdl/dhte_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dhte_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dhte_hash.sv =====
// Hash unit: computes key mod C and key mod (C-1) by restoring division,
// DIV_STEPS bits per cycle. Depends on dhte_pkg.
module dhte_hash #(
    parameter int KEY_WIDTH  = 32,
    parameter int CAP_WIDTH  = 11,
    parameter int ADDR_WIDTH = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [KEY_WIDTH-1:0]      key_in,
    input  logic [CAP_WIDTH-1:0]      cap,
    output dhte_pkg::dhte_unit_st_t   st,
    output logic [ADDR_WIDTH-1:0]     slot_idx,
    output logic [ADDR_WIDTH-1:0]     slot_step
);

    localparam int STEPS = dhte_pkg::DIV_STEPS;
    localparam int NCYC  = (KEY_WIDTH + STEPS - 1) / STEPS;
    localparam int KP    = NCYC * STEPS;
    localparam int NW    = $clog2(NCYC + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic [KP-1:0]         sh_reg, sh_next;
    logic [CAP_WIDTH-1:0]  r0_reg, r0_next;
    logic [CAP_WIDTH-1:0]  r1_reg, r1_next;
    logic [ADDR_WIDTH-1:0] idx_reg, idx_next;
    logic [ADDR_WIDTH-1:0] step_reg, step_next;

    logic [CAP_WIDTH-1:0]  d1;
    logic [CAP_WIDTH-1:0]  r0_it, r1_it;

    assign d1 = cap - CAP_WIDTH'(1);

    // Both remainders stay below their divisors, so one subtract per bit suffices.
    always_comb
    begin
        logic [CAP_WIDTH:0] t0;
        logic [CAP_WIDTH:0] t1;
        r0_it = r0_reg;
        r1_it = r1_reg;
        for (int j = 0; j < STEPS; j++)
        begin
            t0 = {r0_it, sh_reg[KP-1-j]};
            if (t0 >= {1'b0, cap})
            begin
                t0 = t0 - {1'b0, cap};
            end
            r0_it = t0[CAP_WIDTH-1:0];
            t1 = {r1_it, sh_reg[KP-1-j]};
            if (t1 >= {1'b0, d1})
            begin
                t1 = t1 - {1'b0, d1};
            end
            r1_it = t1[CAP_WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        idx_next  = idx_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = KP'(key_in);
            r0_next   = '0;
            r1_next   = '0;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << STEPS;
            r0_next  = r0_it;
            r1_next  = r1_it;
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(NCYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                idx_next  = r0_it[ADDR_WIDTH-1:0];
                // A zero step would never leave the first slot.
                step_next = (r1_it == '0) ? ADDR_WIDTH'(1) : r1_it[ADDR_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        idx_reg  <= idx_next;
        step_reg <= step_next;
    end

    assign st.busy   = busy_reg;
    assign st.done   = done_reg;
    assign slot_idx  = idx_reg;
    assign slot_step = step_reg;

endmodule

// ===== hdl/double_hash_table_engine.sv =====
// Top level of the double hash table engine: probe sequencer, slot RAM, result register.
// Depends on dhte_pkg, dhte_ram, dhte_hash and double_hash_table_engine_defines.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  request  | req_valid, req_stall | operation, key, value
//  response | rsp_valid, rsp_stall | status, read_value, live_entries
//  config   | cfg_valid, cfg_ready | cfg_data (table_capacity)
//
// A put, get or remove first passes through the hash unit, then probes one slot per cycle
// on the slot RAM read port.
// A clear item sweeps the slots in use, one per cycle.
// After reset, and after every capacity write, the same sweep runs before any item is
// taken.
// A finished result waits in the output register while the next item is accepted.
`include "double_hash_table_engine_defines.svh"

module double_hash_table_engine #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [1:0]                         operation,
    input  logic [KEY_WIDTH-1:0]               key,
    input  logic [DATA_WIDTH-1:0]              value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [1:0]                         status,
    output logic [DATA_WIDTH-1:0]              read_value,
    output logic [dhte_pkg::COUNT_WIDTH-1:0]   live_entries,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dhte_pkg::CAP_WIDTH-1:0]     cfg_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int WW  = 2 + KEY_WIDTH + DATA_WIDTH;
    localparam int NTW = dhte_pkg::COUNT_WIDTH;

    dhte_pkg::dhte_state_t  state_reg, state_next;
    dhte_pkg::dhte_op_t     op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [DATA_WIDTH-1:0]  val_reg, val_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          step_reg, step_next;
    logic [CW-1:0]          pcnt_reg, pcnt_next;
    logic                   tomb_valid_reg, tomb_valid_next;
    logic [AW-1:0]          tomb_reg, tomb_next;
    logic [AW-1:0]          sweep_reg, sweep_next;
    logic                   clear_item_reg, clear_item_next;
    logic [NTW-1:0]         count_reg, count_next;
    logic [dhte_pkg::CAP_WIDTH-1:0] cap_reg, cap_next;
    dhte_pkg::dhte_status_t res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0]  res_value_reg, res_value_next;
    logic                   out_valid_reg, out_valid_next;
    dhte_pkg::dhte_status_t out_status_reg, out_status_next;
    logic [DATA_WIDTH-1:0]  out_value_reg, out_value_next;
    logic [NTW-1:0]         out_count_reg, out_count_next;

    logic [CW-1:0]          cap_use;
    logic                   req_acc, cfg_acc, out_free;
    logic                   hash_start;
    dhte_pkg::dhte_unit_st_t hash_st;
    logic [AW-1:0]          hash_idx, hash_step;

    logic                   ram_wr_en, ram_rd_en;
    logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
    logic [WW-1:0]          ram_wr_data, ram_rd_data;

    logic [1:0]             slot_mark;
    logic [KEY_WIDTH-1:0]   slot_key;
    logic [DATA_WIDTH-1:0]  slot_val;
    logic                   is_empty, is_del, is_hit, last_probe, probe_end, sweep_last;
    logic                   tomb_now_valid;
    logic [AW-1:0]          tomb_now, idx_adv;
    logic [SW-1:0]          idx_sum;

    assign req_acc   = req_valid && !req_stall;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != dhte_pkg::S_IDLE);

    // Capacity outside the supported range is clamped.
    always_comb
    begin
        if (cap_reg < dhte_pkg::CAP_WIDTH'(2))
        begin
            cap_use = CW'(2);
        end
        else if (32'(cap_reg) > TABLE_DEPTH)
        begin
            cap_use = CW'(TABLE_DEPTH);
        end
        else
        begin
            cap_use = CW'(cap_reg);
        end
    end

    dhte_hash #(
        .KEY_WIDTH  (KEY_WIDTH),
        .CAP_WIDTH  (CW),
        .ADDR_WIDTH (AW)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (hash_start),
        .key_in    (key),
        .cap       (cap_use),
        .st        (hash_st),
        .slot_idx  (hash_idx),
        .slot_step (hash_step)
    );

    // Each word holds {mark, key, data}. Writes only happen at the end of an item or in
    // a sweep, never while a probe read of the same item is in flight.
    dhte_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign slot_mark = ram_rd_data[WW-1 -: 2];
    assign slot_key  = ram_rd_data[KEY_WIDTH+DATA_WIDTH-1 -: KEY_WIDTH];
    assign slot_val  = ram_rd_data[DATA_WIDTH-1:0];

    assign is_empty   = (slot_mark == dhte_pkg::MARK_EMPTY);
    assign is_del     = (slot_mark == dhte_pkg::MARK_DELETED);
    assign is_hit     = (slot_mark == dhte_pkg::MARK_USED) && (slot_key == key_reg);
    assign last_probe = (pcnt_reg == cap_use - CW'(1));
    assign probe_end  = is_empty || is_hit || last_probe;
    assign sweep_last = (CW'(sweep_reg) == cap_use - CW'(1));

    // The slot under the current probe counts as the first deleted one if none came before.
    assign tomb_now_valid = tomb_valid_reg || is_del;
    assign tomb_now       = tomb_valid_reg ? tomb_reg : idx_reg;

    always_comb
    begin
        idx_sum = SW'(idx_reg) + SW'(step_reg);
        if (idx_sum >= SW'(cap_use))
        begin
            idx_sum = idx_sum - SW'(cap_use);
        end
        idx_adv = idx_sum[AW-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhte_pkg::S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = clear_item_reg ? dhte_pkg::S_FINISH : dhte_pkg::S_IDLE;
                end
            end
            dhte_pkg::S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = (operation == dhte_pkg::OP_CLEAR) ? dhte_pkg::S_SWEEP
                                                                   : dhte_pkg::S_HASH;
                end
            end
            dhte_pkg::S_HASH:
            begin
                if (hash_st.done)
                begin
                    state_next = dhte_pkg::S_PROBE;
                end
            end
            dhte_pkg::S_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = dhte_pkg::S_FINISH;
                end
            end
            dhte_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dhte_pkg::S_IDLE;
                end
            end
        endcase
        if (cfg_acc)
        begin
            state_next = dhte_pkg::S_SWEEP;
        end
    end

    // Datapath and memory control.
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        pcnt_next       = pcnt_reg;
        tomb_valid_next = tomb_valid_reg;
        tomb_next       = tomb_reg;
        sweep_next      = sweep_reg;
        clear_item_next = clear_item_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        hash_start      = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = {dhte_pkg::MARK_USED, key_reg, val_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg;

        unique case (state_reg)
            dhte_pkg::S_SWEEP:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = sweep_reg;
                ram_wr_data = {dhte_pkg::MARK_EMPTY, {(KEY_WIDTH + DATA_WIDTH){1'b0}}};
                sweep_next  = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    clear_item_next = 1'b0;
                end
            end
            dhte_pkg::S_IDLE:
            begin
                if (req_acc)
                begin
                    op_next  = dhte_pkg::dhte_op_t'(operation);
                    key_next = key;
                    val_next = value;
                    if (operation == dhte_pkg::OP_CLEAR)
                    begin
                        sweep_next      = '0;
                        clear_item_next = 1'b1;
                        count_next      = '0;
                        res_status_next = dhte_pkg::ST_OK;
                        res_value_next  = '0;
                    end
                    else
                    begin
                        hash_start = 1'b1;
                    end
                end
            end
            dhte_pkg::S_HASH:
            begin
                if (hash_st.done)
                begin
                    idx_next        = hash_idx;
                    step_next       = hash_step;
                    pcnt_next       = '0;
                    tomb_valid_next = 1'b0;
                    ram_rd_en       = 1'b1;
                    ram_rd_addr     = hash_idx;
                end
            end
            dhte_pkg::S_PROBE:
            begin
                if (!probe_end)
                begin
                    pcnt_next   = pcnt_reg + CW'(1);
                    idx_next    = idx_adv;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_adv;
                    if (is_del && !tomb_valid_reg)
                    begin
                        tomb_valid_next = 1'b1;
                        tomb_next       = idx_reg;
                    end
                end
                else
                begin
                    res_status_next = dhte_pkg::ST_OK;
                    res_value_next  = '0;
                    unique case (op_reg)
                        dhte_pkg::OP_PUT:
                        begin
                            if (is_hit)
                            begin
                                ram_wr_en = 1'b1;
                            end
                            else if (tomb_now_valid)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = tomb_now;
                                count_next  = count_reg + NTW'(1);
                            end
                            else if (is_empty)
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + NTW'(1);
                            end
                            else
                            begin
                                res_status_next = dhte_pkg::ST_FULL;
                            end
                        end
                        dhte_pkg::OP_GET:
                        begin
                            if (is_hit)
                            begin
                                res_value_next = slot_val;
                            end
                            else
                            begin
                                res_status_next = dhte_pkg::ST_NOT_FOUND;
                            end
                        end
                        dhte_pkg::OP_REMOVE:
                        begin
                            if (is_hit)
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_data = {dhte_pkg::MARK_DELETED, slot_key, slot_val};
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - NTW'(1);
                                end
                            end
                            else
                            begin
                                res_status_next = dhte_pkg::ST_NOT_FOUND;
                            end
                        end
                        dhte_pkg::OP_CLEAR:
                        begin
                            // A clear item goes through the sweep and never probes.
                            res_status_next = dhte_pkg::ST_OK;
                        end
                    endcase
                end
            end
            dhte_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_count_next  = count_reg;
                end
            end
        endcase

        // A capacity write empties the table through a fresh sweep.
        if (cfg_acc)
        begin
            cap_next        = cfg_data;
            sweep_next      = '0;
            count_next      = '0;
            clear_item_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dhte_pkg::S_SWEEP;
            sweep_reg      <= '0;
            clear_item_reg <= 1'b0;
            count_reg      <= '0;
            cap_reg        <= dhte_pkg::CAP_RESET;
            pcnt_reg       <= '0;
            tomb_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clear_item_reg <= clear_item_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            pcnt_reg       <= pcnt_next;
            tomb_valid_reg <= tomb_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        tomb_reg       <= tomb_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign read_value   = out_value_reg;
    assign live_entries = out_count_reg;

    // The live count can never exceed the number of slots in use.
    `DHTE_CHECK(a_count_bound, 1'b1, (SW'(count_reg) <= SW'(cap_use)), "live count exceeds capacity")
    // Probing starts only once both remainders are final.
    `DHTE_CHECK(a_probe_after_hash, (state_reg == dhte_pkg::S_PROBE), !hash_st.busy, "probe while hashing")
    // A capacity write always empties the table and restarts the sweep.
    `DHTE_CHECK_NEXT(a_cfg_wipes, cfg_acc, ((state_reg == dhte_pkg::S_SWEEP) && (count_reg == '0) && (sweep_reg == '0)), "capacity write did not wipe")

endmodule
